### src/pnh_pkg.sv
// shared constants and state types for the path name hash
package pnh_pkg;

   localparam int MAX_CHARS_DEF = 256;
   localparam int CHAR_W        = 8;
   localparam int WORD_W        = 32;

   // closing words mixed after the string
   localparam logic [31:0] TAIL_WORD0 = 32'h9BE7_4448;
   localparam logic [31:0] TAIL_WORD1 = 32'h66F4_2C48;

   // state after reset or reload
   localparam logic [31:0] ROT_INIT = 32'hF4FA_8928;
   localparam logic [31:0] A_INIT   = 32'h37A8_470E;
   localparam logic [31:0] C_INIT   = 32'h7758_B42B;

   // round constants
   localparam logic [31:0] B_KEY  = 32'h267B_0B11;
   localparam logic [31:0] D1_OR  = 32'h0204_0801;
   localparam logic [31:0] D1_AND = 32'hBFEF_7FDF;
   localparam logic [31:0] D2_OR  = 32'h0080_4021;
   localparam logic [31:0] D2_AND = 32'h7DFE_FBFF;

   // round sequencer of the mixing unit
   typedef enum logic [4:0] {
      M_IDLE = 5'b00001,
      M_MUL1 = 5'b00010,
      M_MUL2 = 5'b00100,
      M_FIN1 = 5'b01000,
      M_FIN2 = 5'b10000
   } mix_state_type;

   // item sequencer of the top level
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHAR  = 7'b0000010,
      ST_CLOSE = 7'b0000100,
      ST_PART  = 7'b0001000,
      ST_TAIL0 = 7'b0010000,
      ST_TAIL1 = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } seq_state_type;

endpackage

### src/pnh_channels.sv
// valid/ready channel interfaces for character items and hash results
interface pnh_req_if;
   logic                         valid;
   logic                         ready;
   logic [pnh_pkg::CHAR_W-1:0]   char_code;
   logic                         has_char;
   logic                         last;

   modport source (output valid, output char_code, output has_char, output last,
                   input ready);
   modport sink   (input valid, input char_code, input has_char, input last,
                   output ready);
endinterface

interface pnh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pnh_pkg::WORD_W-1:0]   hash;

   modport source (output valid, output hash, input ready);
   modport sink   (input valid, input hash, output ready);
endinterface

### src/pnh_mul.sv
// registered 32x32 unsigned multiplier shared by both products of a round
module pnh_mul (
   input  logic        clock,
   input  logic [31:0] mul_x,
   input  logic [31:0] mul_y,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = {32'b0, mul_x} * {32'b0, mul_y};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### src/pnh_mix.sv
// one mixing round per start, stepped through the shared multiplier
module pnh_mix (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] word,
   input  logic        reload,
   output logic [31:0] acc_a,
   output logic [31:0] acc_c,
   output logic        done
);

   pnh_pkg::mix_state_type state_ff, state_in;
   logic [31:0] rot_ff, rot_in;
   logic [31:0] acc_a_ff, acc_a_in;
   logic [31:0] acc_c_ff, acc_c_in;
   logic [31:0] a_op_ff, a_op_in;
   logic [31:0] c_op_ff, c_op_in;
   logic [31:0] d1_ff, d1_in;
   logic [31:0] d2_ff, d2_in;
   logic [32:0] sum_ff, sum_in;

   logic [31:0] rot_rl, b_key, a_x, c_x;
   logic [31:0] mul_x, mul_y;
   logic [63:0] prod;
   logic [31:0] lo, hi;
   logic [32:0] sum_a, sum_c;

   pnh_mul u_mul (
      .clock (clock),
      .mul_x (mul_x),
      .mul_y (mul_y),
      .prod  (prod)
   );

   // operand preparation for a fresh word
   assign rot_rl = {rot_ff[30:0], rot_ff[31]};
   assign b_key  = pnh_pkg::B_KEY ^ rot_rl;
   assign a_x    = acc_a_ff ^ word;
   assign c_x    = acc_c_ff ^ word;

   assign lo = prod[31:0];
   assign hi = prod[63:32];

   // a: lo + hi + (hi != 0); c: lo + 2*hi + carry of 2*hi
   assign sum_a = {1'b0, lo} + {1'b0, hi} + {32'b0, (hi != 32'b0)};
   assign sum_c = {1'b0, lo} + {1'b0, hi[30:0], 1'b0} + {32'b0, hi[31]};

   // second product uses the c operand
   assign mul_x = (state_ff == pnh_pkg::M_MUL2) ? c_op_ff : a_op_ff;
   assign mul_y = (state_ff == pnh_pkg::M_MUL2) ? d2_ff : d1_ff;

   always_comb begin
      state_in = state_ff;
      rot_in   = rot_ff;
      acc_a_in = acc_a_ff;
      acc_c_in = acc_c_ff;
      a_op_in  = a_op_ff;
      c_op_in  = c_op_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      sum_in   = sum_ff;
      case (state_ff)
         pnh_pkg::M_IDLE: begin
            if (start) begin
               rot_in   = rot_rl;
               a_op_in  = a_x;
               c_op_in  = c_x;
               d1_in    = ((b_key + c_x) | pnh_pkg::D1_OR) & pnh_pkg::D1_AND;
               d2_in    = ((b_key + a_x) | pnh_pkg::D2_OR) & pnh_pkg::D2_AND;
               state_in = pnh_pkg::M_MUL1;
            end
         end
         pnh_pkg::M_MUL1: begin
            state_in = pnh_pkg::M_MUL2;
         end
         pnh_pkg::M_MUL2: begin
            sum_in   = sum_a;
            state_in = pnh_pkg::M_FIN1;
         end
         pnh_pkg::M_FIN1: begin
            acc_a_in = sum_ff[31:0] + {31'b0, sum_ff[32]};
            sum_in   = sum_c;
            state_in = pnh_pkg::M_FIN2;
         end
         pnh_pkg::M_FIN2: begin
            acc_c_in = sum_ff[31:0] + {30'b0, sum_ff[32], 1'b0};
            state_in = pnh_pkg::M_IDLE;
         end
         default: begin
            state_in = pnh_pkg::M_IDLE;
         end
      endcase
      if (reload) begin
         rot_in   = pnh_pkg::ROT_INIT;
         acc_a_in = pnh_pkg::A_INIT;
         acc_c_in = pnh_pkg::C_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pnh_pkg::M_IDLE;
         rot_ff   <= pnh_pkg::ROT_INIT;
         acc_a_ff <= pnh_pkg::A_INIT;
         acc_c_ff <= pnh_pkg::C_INIT;
      end else begin
         state_ff <= state_in;
         rot_ff   <= rot_in;
         acc_a_ff <= acc_a_in;
         acc_c_ff <= acc_c_in;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff <= a_op_in;
      c_op_ff <= c_op_in;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      sum_ff  <= sum_in;
   end

   assign acc_a = acc_a_ff;
   assign acc_c = acc_c_ff;
   assign done  = (state_ff == pnh_pkg::M_FIN2);

endmodule

### src/path_name_hash.sv
// top level of the path name hash: character intake, word packing and round sequencing
//
// usage
//  - req channel: one item per character, with has_char and last flags;
//    a zero character or one beyond MAX_CHARS is dropped, last still acts
//  - rsp channel: one hash item for every request item that carries last
//  - upper-case letters fold to lower case and '/' becomes '\' before packing
// intake and rounds
//  - an item that does not complete a word and is not last leaves req ready high
//  - an item completing a 32-bit word holds req ready low for one round,
//    set by the five-step round through the one multiplier
//  - a last item runs up to three rounds (the word it completes or a partial
//    word, then two closing words) plus the close and emit states
//  - one item at a time; req ready is high only while the sequencer is idle
// reset and stalls
//  - synchronous reset loads the initial hash state and empties the packer
//  - the hash sits in an output register; a new string may be taken while it
//    waits, but the next hash is held back until the receiver takes the old one
module path_name_hash #(
   parameter int MAX_CHARS = pnh_pkg::MAX_CHARS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pnh_req_if.sink   req,
   pnh_rsp_if.source rsp
);

   localparam int CNT_W = $clog2(MAX_CHARS + 1);

   pnh_pkg::seq_state_type state_ff, state_in;
   logic             issued_ff, issued_in;
   logic             last_ff, last_in;
   logic [23:0]      pack_ff, pack_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      word_ff, word_in;
   logic [31:0]      hash_ff, hash_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic        accept;
   logic        take;
   logic [7:0]  adj;
   logic [1:0]  pos;
   logic        mix_state;
   logic        mix_start;
   logic        mix_done;
   logic        reload;
   logic [31:0] mix_word;
   logic [31:0] acc_a, acc_c;

   // case folding and separator swap
   function automatic logic [7:0] adjust_char(input logic [7:0] ch);
      logic [7:0] r;
      r = ch;
      if (ch inside {[8'h41:8'h5A]}) begin
         r = ch + 8'h20;
      end else if (ch == 8'h2F) begin
         r = 8'h5C;
      end
      return r;
   endfunction

   pnh_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .start  (mix_start),
      .word   (mix_word),
      .reload (reload),
      .acc_a  (acc_a),
      .acc_c  (acc_c),
      .done   (mix_done)
   );

   assign req.ready = (state_ff == pnh_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;

   // character kept only if nonzero and below the length limit
   assign take = req.has_char && (req.char_code != 8'h00) &&
                 (count_ff < CNT_W'(MAX_CHARS));
   assign adj  = adjust_char(req.char_code);
   assign pos  = count_ff[1:0];

   // kick one round on the first cycle of each mixing state
   assign mix_state = state_ff inside {pnh_pkg::ST_CHAR, pnh_pkg::ST_PART,
                                       pnh_pkg::ST_TAIL0, pnh_pkg::ST_TAIL1};
   assign mix_start = mix_state && !issued_ff;

   always_comb begin
      case (state_ff)
         pnh_pkg::ST_CHAR:  mix_word = word_ff;
         pnh_pkg::ST_PART:  mix_word = {8'b0, pack_ff};
         pnh_pkg::ST_TAIL0: mix_word = pnh_pkg::TAIL_WORD0;
         pnh_pkg::ST_TAIL1: mix_word = pnh_pkg::TAIL_WORD1;
         default:           mix_word = word_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      pack_in      = pack_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      reload       = 1'b0;

      if (mix_done) begin
         issued_in = 1'b0;
      end else if (mix_start) begin
         issued_in = 1'b1;
      end else begin
         issued_in = issued_ff;
      end

      case (state_ff)
         pnh_pkg::ST_IDLE: begin
            if (accept) begin
               last_in  = req.last;
               state_in = req.last ? pnh_pkg::ST_CLOSE : pnh_pkg::ST_IDLE;
               if (take) begin
                  count_in = count_ff + CNT_W'(1);
                  case (pos)
                     2'd0: pack_in = pack_ff | {16'b0, adj};
                     2'd1: pack_in = pack_ff | {8'b0, adj, 8'b0};
                     2'd2: pack_in = pack_ff | {adj, 16'b0};
                     default: begin
                        // fourth byte completes a word
                        word_in  = {adj, pack_ff};
                        pack_in  = 24'b0;
                        state_in = pnh_pkg::ST_CHAR;
                     end
                  endcase
               end
            end
         end
         pnh_pkg::ST_CHAR: begin
            if (mix_done) begin
               state_in = last_ff ? pnh_pkg::ST_CLOSE : pnh_pkg::ST_IDLE;
            end
         end
         pnh_pkg::ST_CLOSE: begin
            // a partial word is mixed zero-padded
            state_in = (count_ff[1:0] != 2'b00) ? pnh_pkg::ST_PART : pnh_pkg::ST_TAIL0;
         end
         pnh_pkg::ST_PART: begin
            if (mix_done) begin
               state_in = pnh_pkg::ST_TAIL0;
            end
         end
         pnh_pkg::ST_TAIL0: begin
            if (mix_done) begin
               state_in = pnh_pkg::ST_TAIL1;
            end
         end
         pnh_pkg::ST_TAIL1: begin
            if (mix_done) begin
               state_in = pnh_pkg::ST_EMIT;
            end
         end
         pnh_pkg::ST_EMIT: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               hash_in      = acc_a ^ acc_c;
               rsp_valid_in = 1'b1;
               reload       = 1'b1;
               pack_in      = 24'b0;
               count_in     = '0;
               last_in      = 1'b0;
               state_in     = pnh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pnh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pnh_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         last_ff      <= 1'b0;
         pack_ff      <= 24'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         last_ff      <= last_in;
         pack_ff      <= pack_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      hash_ff <= hash_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.hash  = hash_ff;

endmodule

### verif/pnh_hash_checker.sv
`timescale 1ns / 100ps
// hash checker: watches both channels, predicts every hash and compares it
module pnh_hash_checker #(
   parameter int MAX_CHARS = pnh_pkg::MAX_CHARS_DEF
) (
   input  logic clock,
   input  logic reset,
   pnh_req_if   req_mon,
   pnh_rsp_if   rsp_mon,
   output int   error_count,
   output int   due_hashes
);

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CASE_STEP  = 8'h20;

   // predicted hash state
   logic [31:0] rot_r;
   logic [31:0] acc_a;
   logic [31:0] acc_c;
   logic [23:0] pack_r;
   int          kept_chars;

   logic [31:0] hash_due[$];
   logic [31:0] hash_exp;
   int          err_total = 0;
   int          due_total = 0;

   assign error_count = err_total;
   assign due_hashes  = due_total;

   function automatic void reload_state();
      rot_r      = pnh_pkg::ROT_INIT;
      acc_a      = pnh_pkg::A_INIT;
      acc_c      = pnh_pkg::C_INIT;
      pack_r     = '0;
      kept_chars = 0;
   endfunction

   function automatic logic [7:0] fold_char(input logic [7:0] code);
      if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
         return code + CASE_STEP;
      end
      if (code == CH_SLASH) begin
         return CH_BSLASH;
      end
      return code;
   endfunction

   // one mixing round on word w
   function automatic void stir_word(input logic [31:0] w);
      logic [31:0] b;
      logic [31:0] a;
      logic [31:0] c;
      logic [31:0] d1;
      logic [31:0] d2;
      logic [63:0] prod;
      logic [32:0] sum;
      logic [31:0] t;
      rot_r = {rot_r[30:0], rot_r[31]};
      b     = pnh_pkg::B_KEY ^ rot_r;
      a     = acc_a ^ w;
      c     = acc_c ^ w;

      d1    = ((b + c) | pnh_pkg::D1_OR) & pnh_pkg::D1_AND;
      prod  = {32'h0, a} * {32'h0, d1};
      sum   = {1'b0, prod[31:0]} + {1'b0, prod[63:32]} + {32'h0, prod[63:32] != 32'h0};
      acc_a = sum[31:0] + {31'h0, sum[32]};

      // second product uses the pre-round a, not the new acc_a
      d2    = ((b + a) | pnh_pkg::D2_OR) & pnh_pkg::D2_AND;
      prod  = {32'h0, c} * {32'h0, d2};
      sum   = {1'b0, prod[31:0]} + {1'b0, prod[62:32], 1'b0} + {32'h0, prod[63]};
      t     = sum[31:0];
      if (sum[32]) begin
         t = t + 32'd2;
      end
      acc_c = t;
   endfunction

   function automatic void absorb_item(input logic [7:0] code, input logic has,
                                       input logic fin);
      logic [7:0] ch;
      int         pos;
      if (has && code != CH_NUL && kept_chars < MAX_CHARS) begin
         ch  = fold_char(code);
         pos = kept_chars % 4;
         if (pos == 3) begin
            stir_word({ch, pack_r});
            pack_r = '0;
         end else begin
            pack_r = pack_r | ({16'h0, ch} << (8 * pos));
         end
         kept_chars++;
      end
      if (fin) begin
         if (kept_chars % 4 != 0) begin
            stir_word({8'h00, pack_r});
         end
         stir_word(pnh_pkg::TAIL_WORD0);
         stir_word(pnh_pkg::TAIL_WORD1);
         hash_due.push_back(acc_a ^ acc_c);
         reload_state();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reload_state();
         hash_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (hash_due.size() == 0) begin
               $error("hash item with none expected: actual %h", rsp_mon.hash);
               err_total++;
            end else begin
               hash_exp = hash_due.pop_front();
               if (rsp_mon.hash !== hash_exp) begin
                  $error("hash mismatch: expected %h, actual %h", hash_exp, rsp_mon.hash);
                  err_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_item(req_mon.char_code, req_mon.has_char, req_mon.last);
         end
      end
      due_total = hash_due.size();
   end

endmodule

### verif/tb_path_name_hash.sv
`timescale 1ns / 100ps
// testbench top of the path name hash: clock, reset, stimulus, watchdog and verdict
module tb_path_name_hash;

   localparam int MAX_CHARS   = pnh_pkg::MAX_CHARS_DEF;
   localparam int ITEM_GOAL   = 1650;
   localparam int IDLE_LIMIT  = 400;
   localparam int TAIL_CYCLES = 48;

   // characters named for the directed tests
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_ONE     = 8'h01;
   localparam logic [7:0] CH_AT      = 8'h40;   // just below 'A'
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_B = 8'h42;
   localparam logic [7:0] CH_UPPER_Q = 8'h51;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;   // just above 'Z'
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_M = 8'h6D;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_S = 8'h73;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_TOP     = 8'hFF;
   localparam logic [7:0] CH_NOISE   = 8'hAA;

   logic clock;
   logic reset;

   pnh_req_if req_ch ();
   pnh_rsp_if rsp_ch ();

   int error_count;
   int due_hashes;

   int idle_cycles  = 0;
   int sent_items   = 0;   // items accepted on the request channel
   int path_no      = 0;
   bit tx_quiet     = 1'b0; // sender sends back to back for the current path

   path_name_hash #(
      .MAX_CHARS(MAX_CHARS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // prediction and comparison live in the checker; the top only drives
   pnh_hash_checker #(
      .MAX_CHARS(MAX_CHARS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .error_count(error_count),
      .due_hashes (due_hashes)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // every input known from time zero, reset held at the start and released at a falling edge
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.has_char  = 1'b0;
      req_ch.last      = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb_path_name_hash: done, errors");
            $finish;
         end
      end
   end

   // hash receiver: a random stall after each accepted item, with calm runs of none
   initial begin : hash_sink
      int unsigned stall;
      int unsigned calm_left;
      calm_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (calm_left != 0) begin
            stall = 0;
            calm_left--;
         end else if ($urandom_range(0, 7) == 0) begin
            stall     = 0;
            calm_left = $urandom_range(3, 10);
         end else begin
            stall = $urandom_range(0, 17);
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         // wait for the hash to be taken, then step to the next falling edge
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   // one item on the request channel; called and returns at a falling edge
   task automatic send_item(input logic [7:0] code, input logic has, input logic fin);
      int unsigned gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= code;
      req_ch.has_char  <= has;
      req_ch.last      <= fin;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
      @(negedge clock);
   endtask

   // hold the sender off until every predicted hash has been taken
   task automatic drain_hashes();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (due_hashes != 0) @(negedge clock);
   endtask

   // path-like characters: upper-case letters, slashes and printable characters, some anything, some zero or '\'
   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2: begin
            return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
         end
         3: begin
            return CH_SLASH;
         end
         4, 5, 6: begin
            return 8'($urandom_range(8'h20, 8'h7E));
         end
         7, 8: begin
            return 8'($urandom_range(1, 255));
         end
         default: begin
            return $urandom_range(0, 1) ? CH_NUL : CH_BSLASH;
         end
      endcase
   endfunction

   // one random path name, ending in one of several ways
   task automatic send_path(input int unsigned len);
      int unsigned i;
      int unsigned end_kind;
      logic [7:0]  code;
      logic        fin;
      // 0: separate last item without a character, 1: last on a zero character,
      // otherwise last rides on the final character, or on an item without one if len is 0
      end_kind = $urandom_range(0, 9);
      for (i = 0; i < len; i++) begin
         // stray items the block ignores
         if ($urandom_range(0, 11) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         code = pick_char();
         fin  = (i + 1 == len) && (end_kind > 1);
         send_item(code, 1'b1, fin);
      end
      if (len == 0 || end_kind <= 1) begin
         if (end_kind == 1) begin
            send_item(CH_NUL, 1'b1, 1'b1);
         end else begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned sel;
      int unsigned len;
      @(negedge clock);
      while (reset) @(negedge clock);

      // directed: empty string
      send_item(CH_NUL, 1'b0, 1'b1);
      // case folding and slash swap, three characters so a partial word is padded
      send_item(CH_UPPER_A, 1'b1, 1'b0);
      send_item(CH_SLASH, 1'b1, 1'b0);
      send_item(CH_LOWER_Z, 1'b1, 1'b1);
      // letter range edges and character code extremes
      send_item(CH_AT, 1'b1, 1'b0);
      send_item(CH_UPPER_Z, 1'b1, 1'b0);
      send_item(CH_LBRACK, 1'b1, 1'b0);
      send_item(CH_TOP, 1'b1, 1'b0);
      send_item(CH_ONE, 1'b1, 1'b0);
      send_item(CH_BSLASH, 1'b1, 1'b0);
      send_item(CH_LOWER_A, 1'b1, 1'b1);
      // zero character dropped, also when it carries last
      send_item(CH_NUL, 1'b1, 1'b0);
      send_item(CH_UPPER_B, 1'b1, 1'b0);
      send_item(CH_NUL, 1'b1, 1'b1);
      // ignored item, then exactly one full word with no partial left over
      send_item(CH_NOISE, 1'b0, 1'b0);
      send_item(CH_UPPER_Q, 1'b1, 1'b0);
      send_item(CH_LOWER_R, 1'b1, 1'b0);
      send_item(CH_LOWER_S, 1'b1, 1'b0);
      send_item(CH_LOWER_T, 1'b1, 1'b1);
      // last on an item whose character is not taken
      send_item(CH_LOWER_M, 1'b1, 1'b0);
      send_item(CH_LOWER_N, 1'b1, 1'b0);
      send_item(CH_TOP, 1'b0, 1'b1);

      // let everything settle before the random part
      drain_hashes();

      // random paths: mostly short, some medium, a few near or past the character limit
      while (sent_items < ITEM_GOAL) begin
         sel = $urandom_range(0, 99);
         if (sel < 5 || path_no == 3) begin
            len = $urandom_range(MAX_CHARS - 6, MAX_CHARS + 44);
         end else if (sel < 15) begin
            len = $urandom_range(13, 64);
         end else begin
            len = $urandom_range(0, 12);
         end
         tx_quiet = ($urandom_range(0, 3) == 0);
         send_path(len);
         path_no++;
         // now and then wait for the pipeline to empty between paths
         if ($urandom_range(0, 9) == 0) begin
            drain_hashes();
         end
      end

      // all items sent: wait for the outstanding hashes, then watch for strays
      drain_hashes();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0 && due_hashes == 0) begin
         $display("tb_path_name_hash: done, clean");
      end else begin
         $display("tb_path_name_hash: done, errors");
      end
      $finish;
   end

endmodule

### files.f
src/pnh_pkg.sv
src/pnh_channels.sv
src/pnh_mul.sv
src/pnh_mix.sv
src/path_name_hash.sv
verif/pnh_hash_checker.sv
verif/tb_path_name_hash.sv
